### hdl/adsr_pkg.sv
// shared types, constants and constant tables of the adsr envelope generator
package adsr_pkg;

	localparam int LEVEL_FRAC = 24;
	localparam int LEVEL_W    = LEVEL_FRAC + 1;
	localparam int TIME_W     = 21;
	localparam int DUR_W      = 20;
	localparam int MIN_SEG    = 5;
	localparam int VEL_W      = 7;
	localparam int LOG_FB     = 16;
	localparam int LOG_IW     = 5;
	localparam int LOG_W      = LOG_IW + LOG_FB;
	localparam int MANT       = 30;
	localparam int MANT_W     = MANT + 1;
	localparam int PROD_W     = LOG_W + TIME_W;
	localparam int CFG_AW     = 3;
	localparam int CFG_DW     = LEVEL_W;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [MANT_W-1:0] mant_t;
	typedef mant_t [LOG_FB-1:0] coef_tab_t;
	typedef level_t [(1 << VEL_W)-1:0] peak_tab_t;

	localparam level_t FULL_SCALE = {1'b1, {LEVEL_FRAC{1'b0}}};
	localparam level_t LVL_FLOOR  = level_t'(1);
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// envelope phases
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ATT  = 3'd1;
	localparam logic [2:0] PH_DEC  = 3'd2;
	localparam logic [2:0] PH_SUS  = 3'd3;
	localparam logic [2:0] PH_REL  = 3'd4;

	// register indexes
	localparam logic [CFG_AW-1:0] CFG_ATTACK  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_DECAY   = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_SUSTAIN = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_RELEASE = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_LEGATO  = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_VEL     = 3'd5;
	localparam logic [CFG_AW-1:0] CFG_VSCALE  = 3'd6;

	// segment target select
	localparam logic [1:0] SEG_PEAK = 2'd0;
	localparam logic [1:0] SEG_SUS  = 2'd1;
	localparam logic [1:0] SEG_ONE  = 2'd2;

	// segment length select
	localparam logic [1:0] TSEL_ATT = 2'd0;
	localparam logic [1:0] TSEL_DEC = 2'd1;
	localparam logic [1:0] TSEL_REL = 2'd2;

	// level write select
	localparam logic [2:0] LVL_TARGET = 3'd0;
	localparam logic [2:0] LVL_SUS    = 3'd1;
	localparam logic [2:0] LVL_PEAK   = 3'd2;
	localparam logic [2:0] LVL_ONE    = 3'd3;
	localparam logic [2:0] LVL_RAMP   = 3'd4;

	typedef struct packed {
		logic       tick;
		logic       seg_start;
		logic [1:0] seg_val;
		logic [1:0] seg_time;
		logic       phase_we;
		logic [2:0] phase_d;
		logic       busy_we;
		logic       busy_d;
		logic       lvl_we;
		logic [2:0] lvl_sel;
		logic       log_go;
		logic       log_sel;
		logic       cap_la;
		logic       cap_lb;
		logic       mul_go;
		logic       div_go;
		logic       exp_go;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       reached;
		logic       legato;
		logic       log_done;
		logic       div_done;
		logic       exp_done;
		logic       out_free;
	} sts_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// entry k-1 holds floor(2^(2^-k) * 2^30)
	function automatic coef_tab_t make_coefs();
		coef_tab_t t;
		logic [63:0] c;
		c = isqrt64(64'd1 << (2 * MANT + 1));
		t[0] = c[MANT_W-1:0];
		for (int k = 1; k < LOG_FB; k++) begin
			c = isqrt64(c << MANT);
			t[k] = c[MANT_W-1:0];
		end
		return t;
	endfunction

	// velocity/127 of full scale, rounded
	function automatic peak_tab_t make_peaks();
		peak_tab_t t;
		logic [63:0] p;
		for (int v = 0; v < (1 << VEL_W); v++) begin
			p = ((64'(v) << LEVEL_FRAC) + 64'd63) / 64'd127;
			t[v] = p[LEVEL_W-1:0];
		end
		return t;
	endfunction

	localparam coef_tab_t EXP_COEF = make_coefs();
	localparam peak_tab_t PEAK_TAB = make_peaks();

endpackage

### hdl/adsr_log2.sv
// iterative log2 unit, one squaring step per cycle
module adsr_log2 import adsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  level_t           x,
	output logic             done,
	output logic [LOG_W-1:0] res
);
	localparam int CW = $clog2(LOG_FB);
	localparam logic [CW-1:0] LAST = CW'(LOG_FB - 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [LOG_IW-1:0] n_q;
	logic [LOG_FB-1:0] frac_q;
	mant_t             m_q;
	logic [LOG_IW-1:0] n_nx;
	mant_t             m_init;
	logic [2*MANT_W-1:0] sq;

	// index of the top set bit
	always_comb begin
		n_nx = '0;
		for (int i = 0; i < LEVEL_W; i++) begin
			if (x[i]) n_nx = LOG_IW'(i);
		end
	end

	assign m_init = mant_t'(x) << (LOG_IW'(MANT) - n_nx);
	assign sq     = m_q * m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q    <= n_nx;
			m_q    <= m_init;
			frac_q <= '0;
		end else if (busy_q) begin
			if (sq[2*MANT_W-1]) begin
				frac_q <= {frac_q[LOG_FB-2:0], 1'b1};
				m_q    <= sq[2*MANT_W-1:MANT+1];
			end else begin
				frac_q <= {frac_q[LOG_FB-2:0], 1'b0};
				m_q    <= sq[2*MANT_W-2:MANT];
			end
		end
	end

	assign done = done_q;
	assign res  = {n_q, frac_q};
endmodule

### hdl/adsr_div.sv
// restoring divider, one quotient bit per cycle
module adsr_div import adsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [PROD_W-1:0] dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic              done,
	output logic [LOG_W-1:0]  quo
);
	localparam int CW = $clog2(PROD_W);
	localparam logic [CW-1:0] LAST = CW'(PROD_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [PROD_W-1:0] dvd_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] dsr_q;
	logic [TIME_W:0]   rem_sh;
	logic [TIME_W:0]   diff;
	logic              ge;

	assign rem_sh = {rem_q, dvd_q[PROD_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign diff   = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) busy_q <= 1'b0;
			end
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
			dvd_q <= {dvd_q[PROD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = dvd_q[LOG_W-1:0];
endmodule

### hdl/adsr_dp.sv
// envelope datapath: settings, envelope state, log/div/exp units, output register
module adsr_dp import adsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_valid,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              out_ready,
	output logic              out_valid,
	output level_t            out_level,
	output logic [2:0]        out_phase,
	output logic              out_busy
);
	localparam int ECW = $clog2(LOG_FB);
	localparam logic [ECW-1:0] ELAST = ECW'(LOG_FB - 1);

	logic [DUR_W-1:0] att_q, dec_q, rel_q;
	level_t           sus_q;
	logic             legato_q, vscale_q;
	logic [VEL_W-1:0] vel_q;

	logic [2:0]        phase_q;
	level_t            level_q, start_q, target_q;
	logic [TIME_W-1:0] elapsed_q, len_q;
	logic              busy_q, reached_q;

	logic [LOG_W-1:0]  la_q, lb_q;
	logic [PROD_W-1:0] prod_q;
	logic [LOG_W-1:0]  v_q;
	mant_t             r_q;
	logic              exp_busy_q, exp_done_q;
	logic [ECW-1:0]    exp_cnt_q;
	logic              out_vld_q;

	level_t            peak_val, sus_val, seg_v, lvl_nx, ramp_lvl, raw_lvl, lo, hi;
	logic [DUR_W-1:0]  seg_t;
	logic [TIME_W:0]   len_sum;
	logic [TIME_W-1:0] len_nx, elapsed_inc;
	logic              log_done, div_done, up;
	logic [LOG_W-1:0]  log_res, quo, mag, v_nx;
	logic [LOG_FB-1:0] v_frac;
	logic [2*MANT_W-1:0] exp_mul;
	mant_t             shifted;

	assign peak_val = vscale_q ? PEAK_TAB[vel_q] : FULL_SCALE;
	assign sus_val  = (sus_q > FULL_SCALE) ? FULL_SCALE : sus_q;

	always_comb begin
		case (cmd.seg_val)
			SEG_PEAK: seg_v = peak_val;
			SEG_SUS:  seg_v = sus_val;
			SEG_ONE:  seg_v = LVL_FLOOR;
			default:  seg_v = LVL_FLOOR;
		endcase
		case (cmd.seg_time)
			TSEL_ATT: seg_t = att_q;
			TSEL_DEC: seg_t = dec_q;
			TSEL_REL: seg_t = rel_q;
			default:  seg_t = rel_q;
		endcase
	end

	assign len_sum     = (TIME_W+1)'(seg_t) + (TIME_W+1)'(MIN_SEG);
	assign len_nx      = (len_sum > {1'b0, TIME_MAX}) ? TIME_MAX : len_sum[TIME_W-1:0];
	assign elapsed_inc = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + 1'b1;

	// ramp value: exp2 result scaled by the integer part, clamped to the segment ends
	assign shifted  = r_q >> (LOG_IW'(MANT) - v_q[LOG_W-1:LOG_FB]);
	assign raw_lvl  = shifted[LEVEL_W-1:0];
	assign lo       = (start_q < target_q) ? start_q : target_q;
	assign hi       = (start_q < target_q) ? target_q : start_q;
	assign ramp_lvl = (raw_lvl < lo) ? lo : ((raw_lvl > hi) ? hi : raw_lvl);

	always_comb begin
		case (cmd.lvl_sel)
			LVL_TARGET: lvl_nx = target_q;
			LVL_SUS:    lvl_nx = sus_val;
			LVL_PEAK:   lvl_nx = peak_val;
			LVL_ONE:    lvl_nx = LVL_FLOOR;
			LVL_RAMP:   lvl_nx = ramp_lvl;
			default:    lvl_nx = target_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q    <= '0;
			dec_q    <= DUR_W'(24000);
			sus_q    <= '0;
			rel_q    <= DUR_W'(24000);
			legato_q <= 1'b0;
			vel_q    <= {VEL_W{1'b1}};
			vscale_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				CFG_ATTACK:  att_q    <= cfg_data[DUR_W-1:0];
				CFG_DECAY:   dec_q    <= cfg_data[DUR_W-1:0];
				CFG_SUSTAIN: sus_q    <= cfg_data[LEVEL_W-1:0];
				CFG_RELEASE: rel_q    <= cfg_data[DUR_W-1:0];
				CFG_LEGATO:  legato_q <= cfg_data[0];
				CFG_VEL:     vel_q    <= cfg_data[VEL_W-1:0];
				CFG_VSCALE:  vscale_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			level_q   <= LVL_FLOOR;
			start_q   <= LVL_FLOOR;
			target_q  <= LVL_FLOOR;
			elapsed_q <= '0;
			len_q     <= '0;
			busy_q    <= 1'b0;
			reached_q <= 1'b0;
		end else begin
			if (cmd.phase_we) phase_q <= cmd.phase_d;
			if (cmd.busy_we) busy_q <= cmd.busy_d;
			if (cmd.lvl_we) level_q <= lvl_nx;
			if (cmd.seg_start) begin
				start_q   <= (level_q == '0) ? LVL_FLOOR : level_q;
				target_q  <= seg_v + 1'b1;
				elapsed_q <= '0;
				len_q     <= len_nx;
				reached_q <= 1'b0;
			end else if (cmd.tick) begin
				elapsed_q <= elapsed_inc;
				if (elapsed_inc >= len_q) reached_q <= 1'b1;
			end
		end
	end

	adsr_log2 u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.log_go),
		.x      (cmd.log_sel ? target_q : start_q),
		.done   (log_done),
		.res    (log_res)
	);

	assign up  = lb_q >= la_q;
	assign mag = up ? lb_q - la_q : la_q - lb_q;

	adsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (prod_q),
		.divisor  (len_q),
		.done     (div_done),
		.quo      (quo)
	);

	assign v_nx    = up ? la_q + quo : la_q - quo;
	assign v_frac  = v_q[LOG_FB-1:0];
	assign exp_mul = r_q * EXP_COEF[exp_cnt_q];

	always_ff @(posedge clk) begin
		if (cmd.cap_la) la_q <= log_res;
		if (cmd.cap_lb) lb_q <= log_res;
		if (cmd.mul_go) prod_q <= PROD_W'(mag) * PROD_W'(elapsed_q);
		if (cmd.exp_go) begin
			v_q <= v_nx;
			r_q <= mant_t'(1) << MANT;
		end else if (exp_busy_q && v_frac[ELAST - exp_cnt_q]) begin
			r_q <= exp_mul[2*MANT_W-2:MANT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_busy_q <= 1'b0;
			exp_done_q <= 1'b0;
			exp_cnt_q  <= '0;
		end else begin
			exp_done_q <= exp_busy_q && (exp_cnt_q == ELAST);
			if (cmd.exp_go) begin
				exp_busy_q <= 1'b1;
				exp_cnt_q  <= '0;
			end else if (exp_busy_q) begin
				exp_cnt_q <= exp_cnt_q + 1'b1;
				if (exp_cnt_q == ELAST) exp_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_level <= level_q;
			out_phase <= phase_q;
			out_busy  <= busy_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign sts.phase    = phase_q;
	assign sts.reached  = reached_q;
	assign sts.legato   = legato_q;
	assign sts.log_done = log_done;
	assign sts.div_done = div_done;
	assign sts.exp_done = exp_done_q;
	assign sts.out_free = !out_vld_q || out_ready;
endmodule

### hdl/adsr_ctrl.sv
// controller: sequences one sample tick through the datapath
module adsr_ctrl import adsr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic key,
	input  sts_t sts,
	output cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_LOGA = 4'd3;
	localparam logic [3:0] S_LOGB = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_DIVG = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_EXP  = 4'd8;
	localparam logic [3:0] S_POST = 4'd9;
	localparam logic [3:0] S_HOLD = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [3:0] state_q, state_nx;
	logic       key_q;
	logic [2:0] ph;

	assign in_ready = (state_q == S_IDLE);
	assign ph       = sts.phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			key_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (in_valid && in_ready) key_q <= key;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_DEC;
			end
			S_DEC: begin
				state_nx = S_OUT;
				if (key_q && !sts.legato) begin
					if (ph != PH_ATT && ph != PH_DEC && ph != PH_SUS) begin
						cmd.busy_we = 1'b1; cmd.busy_d = 1'b1;
						cmd.seg_start = 1'b1; cmd.seg_val = SEG_PEAK; cmd.seg_time = TSEL_ATT;
						cmd.phase_we = 1'b1; cmd.phase_d = PH_ATT;
					end else if (ph == PH_ATT || ph == PH_DEC) begin
						cmd.tick = 1'b1;
						state_nx = S_CHK;
					end
				end else if (key_q) begin
					if (ph != PH_ATT) begin
						cmd.busy_we = 1'b1; cmd.busy_d = 1'b1;
						cmd.seg_start = 1'b1; cmd.seg_val = SEG_PEAK; cmd.seg_time = TSEL_ATT;
						cmd.phase_we = 1'b1; cmd.phase_d = PH_ATT;
					end else begin
						cmd.tick = 1'b1;
						state_nx = S_CHK;
					end
				end else if (!sts.legato) begin
					if (ph != PH_REL && ph != PH_IDLE) begin
						cmd.phase_we = 1'b1; cmd.phase_d = PH_REL;
						cmd.seg_start = 1'b1; cmd.seg_val = SEG_ONE; cmd.seg_time = TSEL_REL;
					end else if (ph == PH_REL) begin
						cmd.tick = 1'b1;
						state_nx = S_CHK;
					end
				end else begin
					// legato release: timed hold in sustain first
					if (ph != PH_SUS && ph != PH_REL && ph != PH_IDLE) begin
						cmd.seg_start = 1'b1; cmd.seg_val = SEG_ONE; cmd.seg_time = TSEL_DEC;
						cmd.phase_we = 1'b1; cmd.phase_d = PH_SUS;
					end else if (ph == PH_SUS) begin
						cmd.tick = 1'b1;
						state_nx = S_HOLD;
					end else if (ph == PH_REL) begin
						cmd.tick = 1'b1;
						state_nx = S_CHK;
					end
				end
			end
			S_CHK: begin
				if (sts.reached) begin
					cmd.lvl_we = 1'b1; cmd.lvl_sel = LVL_TARGET;
					state_nx = S_POST;
				end else begin
					cmd.log_go = 1'b1; cmd.log_sel = 1'b0;
					state_nx = S_LOGA;
				end
			end
			S_LOGA: begin
				if (sts.log_done) begin
					cmd.cap_la = 1'b1;
					cmd.log_go = 1'b1; cmd.log_sel = 1'b1;
					state_nx = S_LOGB;
				end
			end
			S_LOGB: begin
				if (sts.log_done) begin
					cmd.cap_lb = 1'b1;
					state_nx = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				state_nx = S_DIVG;
			end
			S_DIVG: begin
				cmd.div_go = 1'b1;
				state_nx = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.exp_go = 1'b1;
					state_nx = S_EXP;
				end
			end
			S_EXP: begin
				if (sts.exp_done) begin
					cmd.lvl_we = 1'b1; cmd.lvl_sel = LVL_RAMP;
					state_nx = S_POST;
				end
			end
			S_POST: begin
				state_nx = S_OUT;
				if (sts.reached) begin
					if (key_q && !sts.legato) begin
						if (ph == PH_ATT) begin
							cmd.phase_we = 1'b1; cmd.phase_d = PH_DEC;
							cmd.seg_start = 1'b1; cmd.seg_val = SEG_SUS; cmd.seg_time = TSEL_DEC;
						end else begin
							cmd.phase_we = 1'b1; cmd.phase_d = PH_SUS;
							cmd.lvl_we = 1'b1; cmd.lvl_sel = LVL_SUS;
						end
					end else if (key_q) begin
						cmd.phase_we = 1'b1; cmd.phase_d = PH_DEC;
						cmd.lvl_we = 1'b1; cmd.lvl_sel = LVL_PEAK;
					end else if (!sts.legato) begin
						cmd.lvl_we = 1'b1; cmd.lvl_sel = LVL_ONE;
						cmd.busy_we = 1'b1; cmd.busy_d = 1'b0;
						cmd.phase_we = 1'b1; cmd.phase_d = PH_IDLE;
					end else begin
						cmd.busy_we = 1'b1; cmd.busy_d = 1'b0;
						cmd.phase_we = 1'b1; cmd.phase_d = PH_IDLE;
					end
				end
			end
			S_HOLD: begin
				state_nx = S_OUT;
				if (sts.reached) begin
					cmd.phase_we = 1'b1; cmd.phase_d = PH_REL;
					cmd.seg_start = 1'b1; cmd.seg_val = SEG_ONE; cmd.seg_time = TSEL_REL;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end
endmodule

### hdl/adsr_envelope_generator.sv
// top level of the adsr envelope generator
//
//  group  dir  handshake               contents
//  s_*    in   s_tvalid / s_tready     s_tdata: [0] key_pressed, [7:1] zero
//  m_*    out  m_tvalid / m_tready     m_tdata: [24:0] env_level, [27:25] env_phase,
//                                               [28] voice_busy, [31:29] zero
//  cfg_*  in   cfg_valid / cfg_ready   cfg_addr register index, cfg_data value
//
// a tick that starts a segment or leaves the envelope as it is goes from decode straight
// to the output register, a legato hold tick passes through the hold state and a tick
// that reaches the end of a ramp through the check and post states; a tick inside a ramp
// runs two 16-step log2 passes on the squaring multiplier, a 42-step restoring divider
// and a 16-step exp2 pass on the coefficient multiplier
// one tick is in flight at a time; the next is taken once the result is in the output
// register, which holds it until m_tready
// arst_n clears the envelope to inactive at one lsb and loads the register defaults
// cfg_ready is always high
module adsr_envelope_generator import adsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [0] key_pressed
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // [24:0] env_level, [27:25] env_phase, [28] voice_busy
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_data
);
	cmd_t       cmd;
	sts_t       sts;
	level_t     out_level;
	logic [2:0] out_phase;
	logic       out_busy;

	adsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.key      (s_tdata[0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	adsr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_level (out_level),
		.out_phase (out_phase),
		.out_busy  (out_busy)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {3'b000, out_busy, out_phase, out_level};
endmodule
